// File: hdl/chirp_excitation_sequencer_top_defines.svh
// Assertion macros shared by the chirp excitation sequencer.
`ifndef CHIRP_EXCITATION_SEQUENCER_TOP_DEFINES_SVH
`define CHIRP_EXCITATION_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define CES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define CES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ces_pkg.sv
// Types, constants and helper functions of the chirp excitation sequencer.
`default_nettype none
package ces_pkg;

  localparam logic [15:0] TICK_RATE    = 16'd32000;
  localparam logic [15:0] TICK_RATE_X2 = 16'd64000;
  localparam logic [22:0] PHASE_MULT   = 23'd5599767;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [15:0] INVALID_PKTS = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [3:0]  DIV_LAST     = 4'd15;
  localparam logic [3:0]  SHIFT_Q15    = 4'd15;
  localparam logic [3:0]  SHIFT_Q8     = 4'd8;

  localparam logic [2:0] REG_START_FREQ    = 3'd0;
  localparam logic [2:0] REG_END_FREQ      = 3'd1;
  localparam logic [2:0] REG_RAMP_RATE     = 3'd2;
  localparam logic [2:0] REG_AMPLITUDE     = 3'd3;
  localparam logic [2:0] REG_OPEN_LOOP     = 3'd4;
  localparam logic [2:0] REG_PHASE_SELECT  = 3'd5;
  localparam logic [2:0] REG_VOLTAGE_ANGLE = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RS_MUL, ST_RS_CHK, ST_RS_DIV, ST_RS_FIN, ST_TICK,
    ST_PH1, ST_PH2, ST_PH3, ST_PH4, ST_PH5, ST_ROM, ST_AMP, ST_VOLT, ST_AB, ST_OUT
  } ces_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RS_MUL, OP_RS_CHK, OP_RS_DIV, OP_RS_FIN, OP_TICK,
    OP_PH1, OP_PH2, OP_PH3, OP_PH4, OP_PH5, OP_ROM, OP_AMP, OP_VOLT, OP_AB, OP_OUT
  } ces_op_t;

  typedef enum logic [1:0] {PH_WAIT, PH_RUN, PH_END} ces_phase_t;

  typedef struct packed {
    ces_op_t op;
  } ces_cmd_t;

  typedef struct packed {
    logic can_emit;
    logic open_loop;
  } ces_status_t;

  typedef struct packed {
    logic [23:0] start_freq;
    logic [23:0] end_freq;
    logic [23:0] ramp_rate;
    logic [15:0] amplitude;
    logic        open_loop;
    logic        phase_select;
    logic [15:0] voltage_angle;
  } ces_cfg_t;

  // Divide by 2^sh rounding toward zero, then clamp to the int16 range.
  function automatic logic signed [15:0] trunc_sat(input logic signed [33:0] p,
                                                   input logic [3:0] sh);
    logic signed [33:0] bias;
    logic signed [33:0] q;
    bias = p[33] ? ((34'sd1 <<< sh) - 34'sd1) : 34'sd0;
    q = (p + bias) >>> sh;
    if (q > 34'sd32767) begin
      return 16'sh7FFF;
    end else if (q < -34'sd32768) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/ces_ctrl.sv
// Sequencing state machine of the chirp excitation sequencer.
`default_nettype none
module ces_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic               s_action,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  input  wire ces_pkg::ces_status_t status,
  output ces_pkg::ces_cmd_t       cmd
);

  ces_pkg::ces_state_t state, state_next;
  logic [3:0] div_cnt, div_cnt_next;
  logic       m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ces_pkg::ST_IDLE;
      div_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      div_cnt  <= div_cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd.op       = ces_pkg::OP_NONE;
    s_tready     = 1'b0;
    case (state)
      ces_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op = ces_pkg::OP_LOAD;
          if (s_action) begin
            state_next = ces_pkg::ST_RS_MUL;
          end else if (status.can_emit) begin
            state_next = ces_pkg::ST_PH1;
          end else begin
            state_next = ces_pkg::ST_TICK;
          end
        end
      end
      ces_pkg::ST_RS_MUL: begin
        cmd.op     = ces_pkg::OP_RS_MUL;
        state_next = ces_pkg::ST_RS_CHK;
      end
      ces_pkg::ST_RS_CHK: begin
        cmd.op       = ces_pkg::OP_RS_CHK;
        div_cnt_next = '0;
        state_next   = ces_pkg::ST_RS_DIV;
      end
      ces_pkg::ST_RS_DIV: begin
        cmd.op       = ces_pkg::OP_RS_DIV;
        div_cnt_next = div_cnt + 4'd1;
        if (div_cnt == ces_pkg::DIV_LAST) begin
          state_next = ces_pkg::ST_RS_FIN;
        end
      end
      ces_pkg::ST_RS_FIN: begin
        cmd.op     = ces_pkg::OP_RS_FIN;
        state_next = ces_pkg::ST_OUT;
      end
      ces_pkg::ST_TICK: begin
        cmd.op     = ces_pkg::OP_TICK;
        state_next = ces_pkg::ST_OUT;
      end
      ces_pkg::ST_PH1: begin
        cmd.op     = ces_pkg::OP_PH1;
        state_next = ces_pkg::ST_PH2;
      end
      ces_pkg::ST_PH2: begin
        cmd.op     = ces_pkg::OP_PH2;
        state_next = ces_pkg::ST_PH3;
      end
      ces_pkg::ST_PH3: begin
        cmd.op     = ces_pkg::OP_PH3;
        state_next = ces_pkg::ST_PH4;
      end
      ces_pkg::ST_PH4: begin
        cmd.op     = ces_pkg::OP_PH4;
        state_next = ces_pkg::ST_PH5;
      end
      ces_pkg::ST_PH5: begin
        cmd.op     = ces_pkg::OP_PH5;
        state_next = ces_pkg::ST_ROM;
      end
      ces_pkg::ST_ROM: begin
        cmd.op     = ces_pkg::OP_ROM;
        state_next = ces_pkg::ST_AMP;
      end
      ces_pkg::ST_AMP: begin
        cmd.op     = ces_pkg::OP_AMP;
        state_next = status.open_loop ? ces_pkg::ST_VOLT : ces_pkg::ST_OUT;
      end
      ces_pkg::ST_VOLT: begin
        cmd.op     = ces_pkg::OP_VOLT;
        state_next = ces_pkg::ST_AB;
      end
      ces_pkg::ST_AB: begin
        cmd.op     = ces_pkg::OP_AB;
        state_next = ces_pkg::ST_OUT;
      end
      ces_pkg::ST_OUT: begin
        // The output register is free once its previous result was taken.
        if (!m_tvalid || m_tready) begin
          cmd.op     = ces_pkg::OP_OUT;
          state_next = ces_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ces_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.op == ces_pkg::OP_OUT) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ces_dp.sv
// Datapath of the chirp excitation sequencer: divider, phase, sine table, scaling.
`default_nettype none
module ces_dp #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ces_pkg::ces_cfg_t  cfg,
  input  wire logic               in_action,
  input  wire logic               in_sync,
  input  wire ces_pkg::ces_cmd_t  cmd,
  output ces_pkg::ces_status_t    status,
  output logic [71:0]             out_data
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW    = 15 + IDX_W;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [14:0] rom_t [SINE_TABLE_DEPTH + 1];

  // Quarter-wave sine in Q0.15 from a truncating Q30 Taylor series.
  function automatic rom_t build_rom();
    rom_t r;
    logic [63:0] x, x2, term, sum, v;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = HALF_PI_Q30 * 64'(i) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 7; k++) begin
        term = (term * x2) >> 30;
        case (k)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          5:       term = term / 110;
          6:       term = term / 156;
          default: term = term / 210;
        endcase
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum + 64'd16384) >> 15;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      r[i] = v[14:0];
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  ces_pkg::ces_phase_t phase_st;
  logic [15:0] idx, limit, packets;
  logic        stream;

  logic        sync_r, valid_r, sat_r, emit_r;
  logic [38:0] num;
  logic [23:0] rem;
  logic [15:0] quo;
  logic [39:0] a_prod;
  logic [31:0] sq;
  logic [55:0] a64, b_prod;
  logic [56:0] nsum;
  logic [54:0] plo;
  logic [31:0] phi;
  logic [15:0] turn_r;
  logic [14:0] rom_q;
  logic        neg_q;
  logic signed [16:0] cos_r;
  logic signed [15:0] v_r, res_smp, res_a, res_b;

  // Combinational helpers
  logic [23:0] diff;
  logic [24:0] div_t;
  logic        div_ge;
  logic [15:0] limit_new;
  logic [16:0] pk_sum;
  logic [47:0] phi_full;
  logic [63:0] phsum;
  logic [15:0] turn_sel;
  logic [14:0] off15;
  logic [PW-1:0] rom_prod;
  logic [IDX_W-1:0] rom_idx;
  logic signed [16:0] sine_val;
  logic signed [33:0] amp_s, sin_s, smp_s, v_s, cos_s;
  logic signed [15:0] s_amp;
  logic rom_en;

  assign status.can_emit  = (phase_st == ces_pkg::PH_RUN) && (idx < limit);
  assign status.open_loop = cfg.open_loop;

  assign diff   = cfg.end_freq - cfg.start_freq;
  assign div_t  = {rem, quo[15]};
  assign div_ge = div_t >= {1'b0, cfg.ramp_rate};

  assign limit_new = !valid_r ? 16'd0 : (sat_r ? ces_pkg::COUNT_MAX : quo);
  assign pk_sum    = {1'b0, limit_new} + 17'd3;

  assign phi_full = 48'(nsum[56:32]) * 48'(ces_pkg::PHASE_MULT);
  assign phsum    = 64'(plo) + {phi, 32'd0};

  always_comb begin
    case (cmd.op)
      ces_pkg::OP_AMP:  turn_sel = cfg.voltage_angle + ces_pkg::QUARTER_TURN;
      ces_pkg::OP_VOLT: turn_sel = cfg.voltage_angle;
      default:          turn_sel = turn_r;
    endcase
  end

  // Odd quadrants read the table mirrored.
  assign off15    = turn_sel[14] ? (15'h4000 - {1'b0, turn_sel[13:0]})
                                 : {1'b0, turn_sel[13:0]};
  assign rom_prod = PW'(off15) * PW'(SINE_TABLE_DEPTH);
  assign rom_idx  = rom_prod[14 +: IDX_W];
  assign rom_en   = (cmd.op == ces_pkg::OP_ROM) || (cmd.op == ces_pkg::OP_AMP) ||
                    (cmd.op == ces_pkg::OP_VOLT);

  assign sine_val = neg_q ? -$signed({2'b00, rom_q}) : $signed({2'b00, rom_q});
  assign amp_s    = $signed({18'd0, cfg.amplitude});
  assign sin_s    = $signed({{17{sine_val[16]}}, sine_val});
  assign smp_s    = $signed({{18{res_smp[15]}}, res_smp});
  assign v_s      = $signed({{18{v_r[15]}}, v_r});
  assign cos_s    = $signed({{17{cos_r[16]}}, cos_r});
  assign s_amp    = ces_pkg::trunc_sat(amp_s * sin_s, ces_pkg::SHIFT_Q15);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_st <= ces_pkg::PH_WAIT;
      idx      <= '0;
      limit    <= '0;
      packets  <= ces_pkg::INVALID_PKTS;
      stream   <= 1'b0;
    end else begin
      case (cmd.op)
        ces_pkg::OP_RS_MUL: begin
          phase_st <= ces_pkg::PH_WAIT;
          idx      <= '0;
          stream   <= 1'b0;
        end
        ces_pkg::OP_RS_FIN: begin
          limit   <= limit_new;
          packets <= valid_r ? (16'(pk_sum[16:2]) + 16'd1) : ces_pkg::INVALID_PKTS;
        end
        ces_pkg::OP_TICK: begin
          case (phase_st)
            ces_pkg::PH_WAIT: begin
              if (!sync_r) begin
                phase_st <= ces_pkg::PH_RUN;
                stream   <= 1'b1;
              end
            end
            ces_pkg::PH_RUN: begin
              if (!sync_r) begin
                phase_st <= ces_pkg::PH_END;
                stream   <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        ces_pkg::OP_AMP: begin
          idx <= idx + 16'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rom_en) begin
      rom_q <= SINE_ROM[rom_idx];
      neg_q <= turn_sel[15];
    end
    case (cmd.op)
      ces_pkg::OP_LOAD: begin
        sync_r  <= in_sync;
        res_smp <= '0;
        res_a   <= '0;
        res_b   <= '0;
        emit_r  <= 1'b0;
      end
      ces_pkg::OP_RS_MUL: begin
        valid_r <= cfg.start_freq < cfg.end_freq;
        num     <= 39'(diff) * 39'(ces_pkg::TICK_RATE);
      end
      ces_pkg::OP_RS_CHK: begin
        // A quotient of 2^16 or more saturates; this also covers a zero ramp.
        sat_r <= {1'b0, num[38:16]} >= cfg.ramp_rate;
        rem   <= {1'b0, num[38:16]};
        quo   <= num[15:0];
      end
      ces_pkg::OP_RS_DIV: begin
        rem <= div_ge ? 24'(div_t - {1'b0, cfg.ramp_rate}) : div_t[23:0];
        quo <= {quo[14:0], div_ge};
      end
      ces_pkg::OP_PH1: begin
        a_prod <= 40'(cfg.start_freq) * 40'(idx);
        sq     <= 32'(idx) * 32'(idx);
      end
      ces_pkg::OP_PH2: begin
        a64    <= 56'(a_prod) * 56'(ces_pkg::TICK_RATE_X2);
        b_prod <= 56'(cfg.ramp_rate) * 56'(sq);
      end
      ces_pkg::OP_PH3: begin
        nsum <= 57'(a64) + 57'(b_prod);
      end
      ces_pkg::OP_PH4: begin
        plo <= 55'(nsum[31:0]) * 55'(ces_pkg::PHASE_MULT);
        phi <= phi_full[31:0];
      end
      ces_pkg::OP_PH5: begin
        turn_r <= phsum[63:48];
      end
      ces_pkg::OP_AMP: begin
        res_smp <= s_amp;
        res_a   <= cfg.phase_select ? 16'sd0 : s_amp;
        res_b   <= cfg.phase_select ? s_amp : 16'sd0;
        emit_r  <= 1'b1;
      end
      ces_pkg::OP_VOLT: begin
        v_r   <= ces_pkg::trunc_sat(smp_s * amp_s, ces_pkg::SHIFT_Q8);
        cos_r <= sine_val;
      end
      ces_pkg::OP_AB: begin
        res_a   <= ces_pkg::trunc_sat(v_s * cos_s, ces_pkg::SHIFT_Q15);
        res_b   <= ces_pkg::trunc_sat(v_s * sin_s, ces_pkg::SHIFT_Q15);
        res_smp <= ces_pkg::trunc_sat(v_s * cos_s, ces_pkg::SHIFT_Q15);
      end
      ces_pkg::OP_OUT: begin
        out_data <= {5'd0, packets, (phase_st == ces_pkg::PH_END), stream, emit_r,
                     res_b, res_a, res_smp};
      end
      default: begin
      end
    endcase
  end

  // The restart item's action bit only steers the controller.
  logic unused_action;
  assign unused_action = in_action;

endmodule
`default_nettype wire

// File: hdl/chirp_excitation_sequencer_top.sv
// Top level of the chirp excitation sequencer: register port, controller and datapath.
// Restart items run a multiply, a check, the 16-step divider and a final step; emitting
// ticks run the phase multiplies, table read and scaling, plus voltage and a/b steps in
// open loop; other ticks run a single tick step. Each then waits for the output register,
// and the next request is taken only once back in idle. Synchronous active-high reset:
// wait for sync, index and limit 0, packet count 65535, registers 0, no result pending.
`default_nettype none
`include "chirp_excitation_sequencer_top_defines.svh"
module chirp_excitation_sequencer_top #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] sync_flag, [7:1] zero
  input  wire logic        s_tuser,   // [0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [15:0] sample, [31:16] out_a, [47:32] out_b, [48] emitting,
  // [49] record_active, [50] finished, [66:51] package_count, [71:67] zero
  output logic [71:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  ces_pkg::ces_cfg_t    cfg;
  ces_pkg::ces_cmd_t    cmd;
  ces_pkg::ces_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        ces_pkg::REG_START_FREQ:    cfg.start_freq    <= pwdata[23:0];
        ces_pkg::REG_END_FREQ:      cfg.end_freq      <= pwdata[23:0];
        ces_pkg::REG_RAMP_RATE:     cfg.ramp_rate     <= pwdata[23:0];
        ces_pkg::REG_AMPLITUDE:     cfg.amplitude     <= pwdata[15:0];
        ces_pkg::REG_OPEN_LOOP:     cfg.open_loop     <= pwdata[0];
        ces_pkg::REG_PHASE_SELECT:  cfg.phase_select  <= pwdata[0];
        ces_pkg::REG_VOLTAGE_ANGLE: cfg.voltage_angle <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ces_pkg::REG_START_FREQ:    prdata = {8'd0, cfg.start_freq};
      ces_pkg::REG_END_FREQ:      prdata = {8'd0, cfg.end_freq};
      ces_pkg::REG_RAMP_RATE:     prdata = {8'd0, cfg.ramp_rate};
      ces_pkg::REG_AMPLITUDE:     prdata = {16'd0, cfg.amplitude};
      ces_pkg::REG_OPEN_LOOP:     prdata = {31'd0, cfg.open_loop};
      ces_pkg::REG_PHASE_SELECT:  prdata = {31'd0, cfg.phase_select};
      ces_pkg::REG_VOLTAGE_ANGLE: prdata = {16'd0, cfg.voltage_angle};
      default:                    prdata = '0;
    endcase
  end

  ces_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_action (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ces_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_action (s_tuser),
    .in_sync   (s_tdata[0]),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_tdata)
  );

  logic [6:0] unused_tdata;
  assign unused_tdata = s_tdata[7:1];

  `CES_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")
  `CES_ASSERT_NOW(a_emit_records, m_tvalid && m_tdata[48], m_tdata[49], "sample outside record")
  `CES_ASSERT_NOW(a_end_stops_record, m_tvalid && m_tdata[50], !m_tdata[49], "record after end")

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the chirp excitation sequencer: stream stimulus, APB setup, predictor.
`timescale 1ns / 1ps
module tb_top;
  import ces_pkg::*;

  localparam int DEPTH = 1024;
  localparam int ERR_SHOW = 10;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 30;

  typedef struct packed {
    logic [15:0] pkts;
    logic        fin;
    logic        rec;
    logic        emit;
    logic [15:0] out_b;
    logic [15:0] out_a;
    logic [15:0] smp;
  } chirp_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  chirp_excitation_sequencer_top #(.SINE_TABLE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor copy of the registers and sweep state.
  ces_cfg_t      cfg;
  ces_phase_t    sweep_phase;
  logic [15:0]   sample_idx;
  logic [15:0]   sample_lim;
  logic [15:0]   packet_cnt;
  logic          streaming;
  logic [15:0]   quarter_sine [0:DEPTH];

  chirp_result_t expected_results [$];
  int            mismatches;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            recv_hold_cycles;
  longint        cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void build_quarter_sine();
    longint unsigned x, x2, term, sum, v;
    for (int i = 0; i <= DEPTH; i++) begin
      x = 64'd1686629713 * i / DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      v = (sum + (64'd1 << 14)) >> 15;
      if (v > 32767) v = 32767;
      quarter_sine[i] = v[15:0];
    end
  endfunction

  function automatic longint sine_lookup(input logic [15:0] turn);
    logic [1:0]  quad;
    int          off;
    int          idx;
    longint      v;
    quad = turn[15:14];
    off = turn[13:0];
    if (quad[0]) off = 16384 - off;
    idx = (off * DEPTH) >> 14;
    if (idx > DEPTH) idx = DEPTH;
    v = quarter_sine[idx];
    return quad[1] ? -v : v;
  endfunction

  function automatic longint scale_sat(input longint a, input longint b, input int sh);
    longint q;
    q = (a * b) / (64'sd1 <<< sh);
    if (q > 32767) return 32767;
    if (q < -32768) return -32768;
    return q;
  endfunction

  function automatic logic [15:0] chirp_turn(input logic [15:0] n);
    logic [63:0] num;
    logic [63:0] prod;
    num = 64'(cfg.start_freq) * 64'(n) * 64'd64000 + 64'(cfg.ramp_rate) * 64'(n) * 64'(n);
    prod = num * 64'd5599767;
    return prod[63:48];
  endfunction

  // Advances the predicted sweep by one request and returns the result it should give.
  function automatic chirp_result_t step_sweep(input logic restart, input logic sync);
    chirp_result_t r;
    longint smp, oa, ob, vv;
    longint unsigned cnt;
    smp = 0; oa = 0; ob = 0;
    r = '0;
    if (restart) begin
      sweep_phase = PH_WAIT;
      sample_idx = 0;
      streaming = 1'b0;
      if (cfg.start_freq < cfg.end_freq) begin
        if (cfg.ramp_rate == 0) cnt = 65535;
        else cnt = 64'(cfg.end_freq - cfg.start_freq) * 64'd32000 / 64'(cfg.ramp_rate);
        if (cnt > 65535) cnt = 65535;
        sample_lim = cnt[15:0];
        packet_cnt = 16'((32'(sample_lim) + 3) / 4 + 1);
      end else begin
        sample_lim = 0;
        packet_cnt = 16'hFFFF;
      end
    end else if (sweep_phase == PH_WAIT) begin
      if (!sync) begin
        streaming = 1'b1;
        sweep_phase = PH_RUN;
      end
    end else if (sweep_phase == PH_RUN) begin
      if (sample_idx < sample_lim) begin
        smp = scale_sat(cfg.amplitude, sine_lookup(chirp_turn(sample_idx)), 15);
        if (cfg.open_loop) begin
          vv = scale_sat(smp, cfg.amplitude, 8);
          oa = scale_sat(vv, sine_lookup(cfg.voltage_angle + 16'h4000), 15);
          ob = scale_sat(vv, sine_lookup(cfg.voltage_angle), 15);
          smp = oa;
        end else if (cfg.phase_select) begin
          ob = smp;
        end else begin
          oa = smp;
        end
        r.emit = 1'b1;
        sample_idx = sample_idx + 1;
      end else if (!sync) begin
        sweep_phase = PH_END;
        streaming = 1'b0;
      end
    end
    r.smp = smp[15:0];
    r.out_a = oa[15:0];
    r.out_b = ob[15:0];
    r.rec = streaming;
    r.fin = (sweep_phase == PH_END);
    r.pkts = packet_cnt;
    return r;
  endfunction

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_hold_cycles > 0) begin
      m_tready <= 1'b0;
      recv_hold_cycles <= recv_hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    chirp_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[66:0];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ERR_SHOW) $display("unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        if (got.smp !== want.smp || got.out_a !== want.out_a || got.out_b !== want.out_b ||
            got.emit !== want.emit || got.rec !== want.rec || got.fin !== want.fin ||
            got.pkts !== want.pkts) begin
          mismatches++;
          if (mismatches <= ERR_SHOW)
            $display("mismatch smp %h/%h a %h/%h b %h/%h emit %b/%b rec %b/%b fin %b/%b pk %h/%h",
                     want.smp, got.smp, want.out_a, got.out_a, want.out_b, got.out_b,
                     want.emit, got.emit, want.rec, got.rec, want.fin, got.fin,
                     want.pkts, got.pkts);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic send_request(input logic restart, input logic sync);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= restart;
    s_tdata <= {7'd0, sync};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(step_sweep(restart, sync));
  endtask

  // Lowers valid and waits until every result is in and the block has settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_START_FREQ:    cfg.start_freq = val[23:0];
      REG_END_FREQ:      cfg.end_freq = val[23:0];
      REG_RAMP_RATE:     cfg.ramp_rate = val[23:0];
      REG_AMPLITUDE:     cfg.amplitude = val[15:0];
      REG_OPEN_LOOP:     cfg.open_loop = val[0];
      REG_PHASE_SELECT:  cfg.phase_select = val[0];
      REG_VOLTAGE_ANGLE: cfg.voltage_angle = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [31:0] f0, input logic [31:0] f1, input logic [31:0] rr,
                            input logic [31:0] amp, input logic ol, input logic sel,
                            input logic [31:0] ang);
    drain();
    write_reg(REG_START_FREQ, f0);
    write_reg(REG_END_FREQ, f1);
    write_reg(REG_RAMP_RATE, rr);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_OPEN_LOOP, {31'd0, ol});
    write_reg(REG_PHASE_SELECT, {31'd0, sel});
    write_reg(REG_VOLTAGE_ANGLE, ang);
  endtask

  // Restart, wait for sync, run n ticks with random sync, then close the sweep.
  task automatic run_sweep(input int n);
    send_request(1'b1, $urandom_range(1));
    repeat ($urandom_range(2)) send_request(1'b0, 1'b1);
    send_request(1'b0, 1'b0);
    repeat (n) send_request(1'b0, $urandom_range(1));
    send_request(1'b0, 1'b1);
    send_request(1'b0, 1'b0);
    repeat ($urandom_range(2)) send_request(1'b0, $urandom_range(1));
  endtask

  task automatic test_directed();
    // Invalid sweep: start equals end, then start above end.
    load_setup(32'h1000, 32'h1000, 32'h100, 32'h100, 1'b0, 1'b0, 0);
    run_sweep(2);
    load_setup(32'hFFFFFF, 32'h0, 32'hFFFFFF, 32'hFFFF, 1'b1, 1'b1, 32'hFFFF);
    run_sweep(2);
    // Zero ramp saturates the count; a restart cuts it short.
    load_setup(32'h0, 32'hFFFFFF, 32'h0, 32'hFFFF, 1'b0, 1'b1, 0);
    run_sweep(4);
    // Phase A closed loop, then open loop at extreme amplitude and angle.
    load_setup(32'h0, 32'h200, 32'hFFFFFF, 32'h7FFF, 1'b0, 1'b0, 0);
    run_sweep(10);
    load_setup(32'hFFFF00, 32'hFFFFFF, 32'h3FFFFF, 32'hFFFF, 1'b1, 1'b0, 32'hC000);
    run_sweep(6);
  endtask

  task automatic random_sweeps(input int items);
    int sent, n;
    logic [23:0] f0, rr, span;
    logic [24:0] f1;
    sent = 0;
    while (sent < items) begin
      rr = $urandom_range(24'hFFFFFF, 1);
      if ($urandom_range(9) == 0) rr = 0;
      f0 = $urandom;
      span = $urandom_range(32'(rr >> 9) + 2, 0);
      f1 = 25'(f0) + span;
      if (f1 > 25'hFFFFFF) f1 = 25'hFFFFFF;
      if ($urandom_range(7) == 0) f1 = $urandom;
      load_setup(f0, f1, rr, $urandom, $urandom, $urandom, $urandom);
      n = $urandom_range(60, 1);
      if ($urandom_range(5) == 0) begin
        // Noise: arbitrary requests, restarts included.
        repeat (n) send_request($urandom_range(7) == 0, $urandom_range(1));
      end else begin
        run_sweep(n);
      end
      sent += n + 5;
    end
  endtask

  task automatic test_backpressure();
    load_setup(32'h100, 32'h8000, 32'h800000, 32'h4000, 1'b1, 1'b0, 32'h2000);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold_cycles = 400;
    run_sweep(20);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    recv_hold_cycles = 0; send_idle_pct = 0; recv_stall_pct = 0;
    mismatches = 0;
    cfg = '0;
    sweep_phase = PH_WAIT;
    sample_idx = 0; sample_lim = 0; packet_cnt = 16'hFFFF; streaming = 1'b0;
    build_quarter_sine();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    random_sweeps(400);
    send_idle_pct = 85; recv_stall_pct = 0;
    random_sweeps(400);
    send_idle_pct = 0; recv_stall_pct = 85;
    random_sweeps(400);
    send_idle_pct = 6; recv_stall_pct = 6;
    random_sweeps(400);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/ces_pkg.sv
hdl/ces_ctrl.sv
hdl/ces_dp.sv
hdl/chirp_excitation_sequencer_top.sv
tb/tb_top.sv
